@@ design/hrfs_pkg.sv @@
// ---------------------------------------------------------------------------
// hrfs_pkg
// Shared constants, widths and controller/datapath command types for the
// representative frame selector.
// ---------------------------------------------------------------------------
package hrfs_pkg;

    // Frame geometry
    localparam int BINS        = 3 * 256;
    localparam int MAX_FRAMES  = 32;
    localparam int COUNT_BITS  = 20;

    // Field widths
    localparam int IN_W        = 20;
    localparam int CFG_W       = 6;
    localparam int BEST_W      = 5;
    localparam int USED_W      = 6;
    localparam int ERR_W       = 60;

    // Derived widths
    localparam int BIN_W       = $clog2(BINS);
    localparam int FIDX_W      = $clog2(MAX_FRAMES);
    localparam int CNT_W       = $clog2(MAX_FRAMES + 1);
    localparam int STORE_DEPTH = MAX_FRAMES * BINS;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int SUM_W       = COUNT_BITS + FIDX_W;
    localparam int NH_W        = COUNT_BITS + CNT_W;
    localparam int SQ_W        = 2 * NH_W;

    // Largest bin value that is kept
    localparam logic [IN_W-1:0] SAT_MAX = IN_W'((64'd1 << COUNT_BITS) - 64'd1);

    // Operation codes
    localparam logic OP_BIN   = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                  st_we;      // write bin value into frame store
        logic [ADDR_W-1:0]     st_waddr;
        logic [ADDR_W-1:0]     st_raddr;
        logic [BIN_W-1:0]      sum_raddr;
        logic                  ld;         // bin item accepted: update its sum
        logic                  ld_first;   // first frame of batch: overwrite sum
        logic                  fix;        // remove partial frame bin from sum
        logic                  scan;       // scan read issued
        logic                  scan_first; // first bin of a frame
        logic                  scan_last;  // last bin of a frame
        logic [FIDX_W-1:0]     scan_f;     // frame under scan
        logic [CNT_W-1:0]      n;          // frames in batch
        logic                  out_load;   // move best result to output
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic busy;      // scan pipeline still holds work
        logic out_full;  // output register holds an item
    } t_stat;

endpackage

@@ design/hrfs_if.sv @@
// ---------------------------------------------------------------------------
// hrfs_if
// Valid/ready channels for bin input, selection result and configuration.
// ---------------------------------------------------------------------------
interface hrfs_in_if;
    logic                        valid;
    logic                        ready;
    logic                        op;
    logic [hrfs_pkg::IN_W-1:0]   bin_count;

    modport source (output valid, op, bin_count, input ready);
    modport sink   (input valid, op, bin_count, output ready);
endinterface

interface hrfs_out_if;
    logic                        valid;
    logic                        ready;
    logic [hrfs_pkg::BEST_W-1:0] best_frame;
    logic [hrfs_pkg::USED_W-1:0] frames_used;
    logic [hrfs_pkg::ERR_W-1:0]  scaled_error;

    modport source (output valid, best_frame, frames_used, scaled_error, input ready);
    modport sink   (input valid, best_frame, frames_used, scaled_error, output ready);
endinterface

interface hrfs_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [hrfs_pkg::CFG_W-1:0]  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ design/histogram_representative_frame_select_top.sv @@
// Bin items: one accepted per cycle while no batch is being evaluated.
// Batch end: the scan reads one stored bin per cycle (set by the single read
//   port of the frame store), then the pipeline drains and the output register
//   is loaded when free; a flush first takes a partial frame out of the sums.
// Input stalls from batch end until the result is loaded into the output register.
// Reset (synchronous, active low) clears counters, batch size to 32, no sweep.
// ---------------------------------------------------------------------------
// histogram_representative_frame_select_top
// Picks the frame of a batch whose histogram is closest to the batch mean.
// ---------------------------------------------------------------------------
module histogram_representative_frame_select_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    hrfs_in_if.sink    i_in,
    hrfs_out_if.source o_out,
    hrfs_cfg_if.sink   i_cfg
);
    import hrfs_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // Sequencer
    hrfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_op        (i_in.op),
        .o_in_ready  (i_in.ready),
        .i_cfg_valid (i_cfg.valid),
        .i_cfg_data  (i_cfg.data),
        .o_cfg_ready (i_cfg.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic
    hrfs_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_bin_count    (i_in.bin_count),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_best_frame   (o_out.best_frame),
        .o_frames_used  (o_out.frames_used),
        .o_scaled_error (o_out.scaled_error)
    );

endmodule

@@ design/hrfs_ram.sv @@
// ---------------------------------------------------------------------------
// hrfs_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module hrfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/hrfs_ctrl.sv @@
// ---------------------------------------------------------------------------
// hrfs_ctrl
// Sequencer: counts bins and frames, ends batches, and walks the partial
// frame correction and the scan over all stored frames.
// ---------------------------------------------------------------------------
module hrfs_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  logic                     i_op,
    output logic                     o_in_ready,
    input  logic                     i_cfg_valid,
    input  logic [hrfs_pkg::CFG_W-1:0] i_cfg_data,
    output logic                     o_cfg_ready,
    input  hrfs_pkg::t_stat          i_stat,
    output hrfs_pkg::t_cmd           o_cmd
);
    import hrfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FIX,
        S_FIXW,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_bf;
    logic [BIN_W-1:0]  r_bc,    n_bc;
    logic [CNT_W-1:0]  r_fc,    n_fc;
    logic [ADDR_W-1:0] r_base,  n_base;
    logic [BIN_W-1:0]  r_j,     n_j;
    logic [FIDX_W-1:0] r_f,     n_f;
    logic [ADDR_W-1:0] r_raddr, n_raddr;
    logic [CNT_W-1:0]  r_n,     n_n;
    logic [BIN_W-1:0]  r_part,  n_part;

    logic [CNT_W-1:0]  bsize;
    logic [CNT_W-1:0]  fc_inc;

    // Clamp the batch size into its legal range
    always_comb begin
        if (CNT_W'(r_bf) < CNT_W'(2)) begin
            bsize = CNT_W'(2);
        end else if (CNT_W'(r_bf) > CNT_W'(MAX_FRAMES)) begin
            bsize = CNT_W'(MAX_FRAMES);
        end else begin
            bsize = CNT_W'(r_bf);
        end
    end

    assign fc_inc      = r_fc + 1'b1;
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == S_IDLE);

    // Next state, counters and commands
    always_comb begin
        n_state = r_state;
        n_bc    = r_bc;
        n_fc    = r_fc;
        n_base  = r_base;
        n_j     = r_j;
        n_f     = r_f;
        n_raddr = r_raddr;
        n_n     = r_n;
        n_part  = r_part;

        o_cmd            = '0;
        o_cmd.n          = r_n;
        o_cmd.st_waddr   = r_base + ADDR_W'(r_bc);
        o_cmd.st_raddr   = r_raddr;
        o_cmd.sum_raddr  = r_bc;
        o_cmd.scan_f     = r_f;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_op == OP_FLUSH) begin
                        // End the batch early if a whole frame is stored
                        if (r_fc != '0) begin
                            n_n = r_fc;
                            n_j = '0;
                            n_f = '0;
                            if (r_bc != '0) begin
                                n_part  = r_bc;
                                n_raddr = r_base;
                                n_state = S_FIX;
                            end else begin
                                n_raddr = '0;
                                n_state = S_SCAN;
                            end
                        end
                        n_bc   = '0;
                        n_fc   = '0;
                        n_base = '0;
                    end else begin
                        // Store the bin and update its running sum
                        o_cmd.st_we    = 1'b1;
                        o_cmd.ld       = 1'b1;
                        o_cmd.ld_first = (r_fc == '0);
                        if (r_bc == BIN_W'(BINS - 1)) begin
                            n_bc   = '0;
                            n_fc   = fc_inc;
                            n_base = r_base + ADDR_W'(BINS);
                            if (fc_inc >= bsize) begin
                                n_n     = fc_inc;
                                n_j     = '0;
                                n_f     = '0;
                                n_raddr = '0;
                                n_fc    = '0;
                                n_base  = '0;
                                n_state = S_SCAN;
                            end
                        end else begin
                            n_bc = r_bc + 1'b1;
                        end
                    end
                end
            end
            S_FIX: begin
                // Take the partial frame back out of the sums
                o_cmd.fix       = 1'b1;
                o_cmd.sum_raddr = r_j;
                n_j             = r_j + 1'b1;
                n_raddr         = r_raddr + 1'b1;
                if (r_j == r_part - 1'b1) begin
                    n_state = S_FIXW;
                end
            end
            S_FIXW: begin
                // Let the last corrected sum land before the scan reads it
                n_j     = '0;
                n_f     = '0;
                n_raddr = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                // Issue one bin of one frame per cycle
                o_cmd.scan       = 1'b1;
                o_cmd.sum_raddr  = r_j;
                o_cmd.scan_first = (r_j == '0);
                o_cmd.scan_last  = (r_j == BIN_W'(BINS - 1));
                n_raddr          = r_raddr + 1'b1;
                if (r_j == BIN_W'(BINS - 1)) begin
                    n_j = '0;
                    n_f = r_f + 1'b1;
                    if (r_f == FIDX_W'(r_n - 1'b1)) begin
                        n_state = S_DRAIN;
                    end
                end else begin
                    n_j = r_j + 1'b1;
                end
            end
            S_DRAIN: begin
                if (!i_stat.busy) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hand the result over once the output register is free
                if (!i_stat.out_full) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold state, counters and the batch size register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_bf    <= CFG_W'(MAX_FRAMES);
            r_bc    <= '0;
            r_fc    <= '0;
            r_base  <= '0;
            r_j     <= '0;
            r_f     <= '0;
            r_raddr <= '0;
            r_n     <= '0;
            r_part  <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_bf <= i_cfg_data;
            end
            r_bc    <= n_bc;
            r_fc    <= n_fc;
            r_base  <= n_base;
            r_j     <= n_j;
            r_f     <= n_f;
            r_raddr <= n_raddr;
            r_n     <= n_n;
            r_part  <= n_part;
        end
    end

endmodule

@@ design/hrfs_dp.sv @@
// ---------------------------------------------------------------------------
// hrfs_dp
// Datapath: frame store, per-bin sums, squared-error pipeline, best-frame
// tracking and the output register.
// ---------------------------------------------------------------------------
module hrfs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [hrfs_pkg::IN_W-1:0]     i_bin_count,
    input  hrfs_pkg::t_cmd                i_cmd,
    output hrfs_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hrfs_pkg::BEST_W-1:0]   o_best_frame,
    output logic [hrfs_pkg::USED_W-1:0]   o_frames_used,
    output logic [hrfs_pkg::ERR_W-1:0]    o_scaled_error
);
    import hrfs_pkg::*;

    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last;
        logic [FIDX_W-1:0] f;
    } t_tag;

    // Memory ports
    logic [IN_W-1:0]       v_clip;
    logic [COUNT_BITS-1:0] st_rdata;
    logic [SUM_W-1:0]      sum_rdata;
    logic                  sum_we;
    logic [BIN_W-1:0]      sum_waddr;
    logic [SUM_W-1:0]      sum_wdata;

    // Sum update stage
    logic                  r_ld;
    logic                  r_ld_first;
    logic                  r_fx;
    logic [BIN_W-1:0]      r_addr;
    logic [COUNT_BITS-1:0] r_v;

    // Scan pipeline
    t_tag                  r_tag [1:4];
    logic [NH_W-1:0]       r_nh;
    logic [SUM_W-1:0]      r_s;
    logic [NH_W-1:0]       r_d;
    logic [SQ_W-1:0]       r_sq;
    logic [ERR_W-1:0]      r_acc;
    logic                  r_done;
    logic [FIDX_W-1:0]     r_done_f;
    logic [ERR_W-1:0]      r_best;
    logic [FIDX_W-1:0]     r_bidx;

    // Output register
    logic                  r_ovalid;
    logic [BEST_W-1:0]     r_obest;
    logic [USED_W-1:0]     r_oused;
    logic [ERR_W-1:0]      r_oerr;

    // Saturate the incoming bin value
    assign v_clip = (i_bin_count > SAT_MAX) ? SAT_MAX : i_bin_count;

    hrfs_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.st_we),
        .i_waddr (i_cmd.st_waddr),
        .i_wdata (COUNT_BITS'(v_clip)),
        .i_raddr (i_cmd.st_raddr),
        .o_rdata (st_rdata)
    );

    // Sum write: overwrite on the first frame, add later, subtract on fix
    always_comb begin
        sum_we    = r_ld | r_fx;
        sum_waddr = r_addr;
        if (r_fx) begin
            sum_wdata = sum_rdata - SUM_W'(st_rdata);
        end else if (r_ld_first) begin
            sum_wdata = SUM_W'(r_v);
        end else begin
            sum_wdata = sum_rdata + SUM_W'(r_v);
        end
    end

    hrfs_ram #(
        .WIDTH (SUM_W),
        .DEPTH (BINS)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (i_cmd.sum_raddr),
        .o_rdata (sum_rdata)
    );

    // Control flags of the sum update and scan pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld   <= 1'b0;
            r_fx   <= 1'b0;
            r_tag  <= '{default: '0};
            r_done <= 1'b0;
        end else begin
            r_ld     <= i_cmd.ld;
            r_fx     <= i_cmd.fix;
            r_tag[1] <= '{valid: i_cmd.scan, first: i_cmd.scan_first,
                          last: i_cmd.scan_last, f: i_cmd.scan_f};
            r_tag[2] <= r_tag[1];
            r_tag[3] <= r_tag[2];
            r_tag[4] <= r_tag[3];
            r_done   <= r_tag[4].valid & r_tag[4].last;
        end
    end

    // Payload of the sum update stage
    always_ff @(posedge i_clk) begin
        r_ld_first <= i_cmd.ld_first;
        r_addr     <= i_cmd.sum_raddr;
        r_v        <= COUNT_BITS'(v_clip);
    end

    // Error terms: n*h, |n*h - sum|, square, accumulate
    always_ff @(posedge i_clk) begin
        r_nh <= NH_W'(i_cmd.n) * NH_W'(st_rdata);
        r_s  <= sum_rdata;
        if (r_nh >= NH_W'(r_s)) begin
            r_d <= r_nh - NH_W'(r_s);
        end else begin
            r_d <= NH_W'(r_s) - r_nh;
        end
        r_sq <= SQ_W'(r_d) * SQ_W'(r_d);
        if (r_tag[4].valid) begin
            r_acc <= (r_tag[4].first ? '0 : r_acc) + ERR_W'(r_sq);
        end
        r_done_f <= r_tag[4].f;
    end

    // Keep the earliest frame with the smallest error
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best <= '0;
            r_bidx <= '0;
        end else if (r_done && (r_done_f == '0 || r_acc < r_best)) begin
            r_best <= r_acc;
            r_bidx <= r_done_f;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_obest <= BEST_W'(r_bidx);
            r_oused <= USED_W'(i_cmd.n);
            r_oerr  <= r_best;
        end
    end

    assign o_stat.busy     = r_tag[1].valid | r_tag[2].valid | r_tag[3].valid |
                             r_tag[4].valid | r_done;
    assign o_stat.out_full = r_ovalid;

    assign o_out_valid    = r_ovalid;
    assign o_best_frame   = r_obest;
    assign o_frames_used  = r_oused;
    assign o_scaled_error = r_oerr;

endmodule

@@ design/hrfs_chk.sv @@
// ---------------------------------------------------------------------------
// hrfs_chk
// Port-level checks on the result channel of the frame selector.
// ---------------------------------------------------------------------------
module hrfs_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [hrfs_pkg::BEST_W-1:0]   i_best_frame,
    input logic [hrfs_pkg::USED_W-1:0]   i_frames_used,
    input logic [hrfs_pkg::ERR_W-1:0]    i_scaled_error
);
    import hrfs_pkg::*;

    // Hold a stalled item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            $stable(i_best_frame) && $stable(i_frames_used) && $stable(i_scaled_error))
        else $error("result item changed while stalled");

    // Chosen frame lies inside a non-empty batch
    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_frames_used != '0) &&
            (i_frames_used <= USED_W'(MAX_FRAMES)) &&
            (USED_W'(i_best_frame) < i_frames_used))
        else $error("result frame index out of range");

    // Reset empties the output
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

endmodule

bind histogram_representative_frame_select_top hrfs_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_best_frame   (o_out.best_frame),
    .i_frames_used  (o_out.frames_used),
    .i_scaled_error (o_out.scaled_error)
);

@@ tb/histogram_representative_frame_select_top_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// histogram_representative_frame_select_top_tb
// Streams histogram frames into the selector under random sender gaps and
// receiver stalls, predicts each batch's closest-to-mean frame in the bench,
// and compares every selection result field by field in arrival order.
// ---------------------------------------------------------------------------
module histogram_representative_frame_select_top_tb;

    import hrfs_pkg::*;

    // Cycles to let the block finish trailing work before a register write
    localparam int SETTLE_CYCLES  = 2 * BINS + 64;
    // Longest stretch with no handshake at all before giving up
    localparam int WATCHDOG_LIMIT = 250000;
    // Receiver hold-off length for the back-pressure phase
    localparam int HOLD_CYCLES    = 20000;
    localparam bit [63:0] ERR_MASK = (64'd1 << ERR_W) - 64'd1;

    typedef struct packed {
        logic                  op;
        logic [IN_W-1:0]       bin_count;
    } t_bin_item;

    typedef struct packed {
        logic [BEST_W-1:0]     best_frame;
        logic [USED_W-1:0]     frames_used;
        logic [ERR_W-1:0]      scaled_error;
    } t_selection;

    typedef enum int {FILL_ZERO, FILL_MAX, FILL_RANDOM, FILL_BASE, FILL_NEAR} t_fill_style;

    bit   i_clk;
    logic i_rst_n;

    hrfs_in_if  in_ch ();
    hrfs_out_if out_ch ();
    hrfs_cfg_if cfg_ch ();

    histogram_representative_frame_select_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Clock: 2 ns period
    always #1 i_clk = ~i_clk;

    // Stimulus and checking state
    t_bin_item      bins_to_send [$];
    t_selection     selections_due [$];
    t_selection     want;
    int unsigned    n_pushed;
    int unsigned    n_accepted;
    int unsigned    n_checked;
    int unsigned    n_cfg_writes;
    int unsigned    n_errors;
    int unsigned    quiet_cycles;
    bit             in_fire;
    bit             hold_req;

    // Predictor state: stored frames, per-bin totals, counters, batch register
    bit [IN_W-1:0]  frame_bins [MAX_FRAMES*BINS];
    bit [63:0]      bin_totals [BINS];
    int unsigned    frames_held;
    int unsigned    bins_held;
    logic [CFG_W-1:0] batch_setting = CFG_W'(32);

    // Stimulus shaping
    bit [IN_W-1:0]  base_hist [BINS];
    int unsigned    near_spread;

    // Clamp the batch register to the sizes the block supports
    function automatic int unsigned batch_limit(input logic [CFG_W-1:0] b);
        if (b < 2)
            return 2;
        if (b > MAX_FRAMES)
            return MAX_FRAMES;
        return b;
    endfunction

    // Scan the complete frames, drop a trailing partial frame from the totals,
    // and queue the frame with the smallest scaled squared error
    function automatic void pick_closest_frame(input int unsigned nf, input int unsigned part);
        bit [63:0]   acc;
        bit [63:0]   best_err;
        bit [63:0]   s;
        bit [63:0]   nh;
        bit [63:0]   d;
        int unsigned best_f;
        best_err = '0;
        best_f   = 0;
        for (int unsigned f = 0; f < nf; f++) begin
            acc = '0;
            for (int unsigned j = 0; j < BINS; j++) begin
                s = bin_totals[j];
                if (j < part && nf < MAX_FRAMES)
                    s -= 64'(frame_bins[nf*BINS + j]);
                nh  = 64'(nf) * 64'(frame_bins[f*BINS + j]);
                d   = (nh >= s) ? (nh - s) : (s - nh);
                acc = (acc + d * d) & ERR_MASK;
            end
            if (f == 0 || acc < best_err) begin
                best_err = acc;
                best_f   = f;
            end
        end
        selections_due.push_back('{best_frame:   BEST_W'(best_f),
                                   frames_used:  USED_W'(nf),
                                   scaled_error: ERR_W'(best_err)});
    endfunction

    function automatic void clear_batch();
        foreach (bin_totals[j])
            bin_totals[j] = '0;
        frames_held = 0;
        bins_held   = 0;
    endfunction

    // Advance the predictor by one accepted item
    function automatic void apply_bin_item(input logic op, input logic [IN_W-1:0] cnt);
        logic [IN_W-1:0] v;
        v = (cnt > SAT_MAX) ? SAT_MAX : cnt;
        if (op == OP_FLUSH) begin
            if (frames_held >= 1)
                pick_closest_frame(frames_held, bins_held);
            clear_batch();
        end else begin
            if (frames_held < MAX_FRAMES && bins_held < BINS) begin
                frame_bins[frames_held*BINS + bins_held] = v;
                bin_totals[bins_held] += 64'(v);
            end
            bins_held++;
            if (bins_held >= BINS) begin
                bins_held = 0;
                frames_held++;
                if (frames_held >= batch_limit(batch_setting)) begin
                    pick_closest_frame(frames_held, 0);
                    clear_batch();
                end
            end
        end
    endfunction

    // Queue bins from the start of a frame in the given fill style
    task automatic push_bins(input t_fill_style style, input int unsigned count);
        t_bin_item   item;
        int          v;
        int unsigned j;
        for (j = 0; j < count; j++) begin
            case (style)
                FILL_ZERO:   v = 0;
                FILL_MAX:    v = int'(SAT_MAX);
                FILL_RANDOM: v = int'($urandom_range(0, SAT_MAX));
                FILL_BASE:   v = int'(base_hist[j]);
                default: begin
                    v = int'(base_hist[j]) + int'($urandom_range(0, 2 * near_spread))
                        - int'(near_spread);
                    if (v < 0)
                        v = 0;
                    if (v > int'(SAT_MAX))
                        v = int'(SAT_MAX);
                end
            endcase
            item.op        = OP_BIN;
            item.bin_count = IN_W'(v);
            bins_to_send.push_back(item);
            n_pushed++;
        end
    endtask

    // Queue a flush; its count field carries random junk
    task automatic push_flush();
        t_bin_item item;
        item.op        = OP_FLUSH;
        item.bin_count = IN_W'($urandom_range(0, SAT_MAX));
        bins_to_send.push_back(item);
        n_pushed++;
    endtask

    // Pick a fresh reference histogram and the spread of frames around it
    task automatic roll_base_histogram();
        int unsigned top;
        case ($urandom_range(0, 3))
            0:       top = 255;
            1:       top = 4095;
            2:       top = 65535;
            default: top = SAT_MAX;
        endcase
        foreach (base_hist[j])
            base_hist[j] = IN_W'($urandom_range(0, top));
        near_spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 512);
    endtask

    function automatic t_fill_style random_fill();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return FILL_RANDOM;
        if (r == 1)
            return FILL_BASE;
        if (r == 2)
            return ($urandom_range(0, 1) != 0) ? FILL_MAX : FILL_ZERO;
        return FILL_NEAR;
    endfunction

    // Wait until every item is taken and every selection is back, then idle
    task automatic settle();
        do
            @(negedge i_clk);
        while (n_accepted != n_pushed || selections_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the batch register once the block is idle
    task automatic write_cfg(input logic [CFG_W-1:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do
            @(posedge i_clk);
        while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Driver: offer queued items in bursts separated by random gaps
    int unsigned burst_left;
    int unsigned gap_left;
    t_bin_item   drv_item;

    always @(negedge i_clk) begin
        if (i_rst_n && (!in_ch.valid || in_fire)) begin
            if (gap_left != 0) begin
                gap_left--;
                in_ch.valid <= 1'b0;
            end else if (bins_to_send.size() != 0) begin
                drv_item = bins_to_send.pop_front();
                in_ch.valid     <= 1'b1;
                in_ch.op        <= drv_item.op;
                in_ch.bin_count <= drv_item.bin_count;
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(200, 2000)
                                                             : $urandom_range(1, 40);
                    case ($urandom_range(0, 9))
                        0, 1, 2: gap_left = 0;
                        3:       gap_left = $urandom_range(16, 100);
                        default: gap_left = $urandom_range(1, 15);
                    endcase
                end
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Receiver: stall on a changing pattern, with one long hold-off on request
    int unsigned hold_left;
    bit          hold_done;
    int unsigned rx_mode;
    int unsigned mode_left;
    bit          rx_ready;

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_ready = 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            rx_ready = 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            rx_ready  = 1'b0;
        end else begin
            if (mode_left == 0) begin
                rx_mode   = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 400);
            end else begin
                mode_left--;
            end
            case (rx_mode)
                0:       rx_ready = 1'b1;
                1:       rx_ready = 1'($urandom_range(0, 1));
                2:       rx_ready = ($urandom_range(0, 9) != 0);
                default: rx_ready = ($urandom_range(0, 7) == 0);
            endcase
        end
        out_ch.ready <= rx_ready;
    end

    // Monitor: track register writes, predict on accepted items, check results
    always @(posedge i_clk) begin
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                batch_setting = cfg_ch.data;
                n_cfg_writes++;
            end
            if (in_fire) begin
                n_accepted++;
                apply_bin_item(in_ch.op, in_ch.bin_count);
            end
            if (out_ch.valid && out_ch.ready) begin
                if (selections_due.size() == 0) begin
                    $error("selection with none outstanding: best_frame %0d frames_used %0d",
                           out_ch.best_frame, out_ch.frames_used);
                    n_errors++;
                end else begin
                    want = selections_due.pop_front();
                    if (out_ch.best_frame !== want.best_frame) begin
                        $error("best_frame: expected %0d, actual %0d",
                               want.best_frame, out_ch.best_frame);
                        n_errors++;
                    end
                    if (out_ch.frames_used !== want.frames_used) begin
                        $error("frames_used: expected %0d, actual %0d",
                               want.frames_used, out_ch.frames_used);
                        n_errors++;
                    end
                    if (out_ch.scaled_error !== want.scaled_error) begin
                        $error("scaled_error: expected %0d, actual %0d",
                               want.scaled_error, out_ch.scaled_error);
                        n_errors++;
                    end
                    n_checked++;
                end
            end
            // Watchdog on stretches with no handshake
            if (in_fire || (cfg_ch.valid && cfg_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // Stimulus sequence
    initial begin
        int unsigned cfg_val;
        int unsigned eff;
        int unsigned k;
        int unsigned seg;
        int unsigned random_made;
        int unsigned random_start;

        i_rst_n         = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.op        = OP_BIN;
        in_ch.bin_count = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Flush with nothing stored, then a partial frame alone: no result
        push_flush();
        push_bins(FILL_MAX, 5);
        push_flush();

        // Zero frame against full-scale frame ties; identical frames tie at zero
        write_cfg(CFG_W'(2));
        roll_base_histogram();
        push_bins(FILL_ZERO, BINS);
        push_bins(FILL_MAX, BINS);
        push_bins(FILL_BASE, BINS);
        push_bins(FILL_BASE, BINS);

        // Batch size below range acts as two
        write_cfg(CFG_W'(0));
        push_bins(FILL_RANDOM, BINS);
        push_bins(FILL_RANDOM, BINS);

        // One frame then a partial frame, flushed: partial bins discarded
        write_cfg(CFG_W'(1));
        push_bins(FILL_MAX, BINS);
        push_bins(FILL_RANDOM, 100);
        push_flush();

        // Batch size above range; longest partial frame before the flush
        write_cfg(CFG_W'(33));
        roll_base_histogram();
        repeat (3) push_bins(FILL_NEAR, BINS);
        push_bins(FILL_NEAR, BINS - 1);
        push_flush();

        // Lower the batch size with three frames held: ends at the fourth
        write_cfg(CFG_W'(10));
        repeat (3) push_bins(FILL_NEAR, BINS);
        write_cfg(CFG_W'(2));
        push_bins(FILL_NEAR, BINS);

        // Largest batch once
        write_cfg(CFG_W'(63));
        roll_base_histogram();
        repeat (MAX_FRAMES) push_bins(random_fill(), BINS);

        write_cfg(CFG_W'(32));
        push_bins(FILL_RANDOM, BINS);
        push_flush();

        // Back-pressure: hold the receiver off while several batches stream in
        write_cfg(CFG_W'(2));
        roll_base_histogram();
        @(posedge i_clk);
        hold_req = 1'b1;
        repeat (8) push_bins(FILL_NEAR, BINS);

        // Random phases: mostly small batches, some flushes and stray items
        random_made  = 0;
        random_start = n_pushed;
        while (random_made < 40 || n_pushed - random_start < 2000) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: cfg_val = $urandom_range(2, 5);
                6:                cfg_val = $urandom_range(0, 1);
                7, 8:             cfg_val = $urandom_range(6, 31);
                default:          cfg_val = $urandom_range(32, 63);
            endcase
            eff = batch_limit(CFG_W'(cfg_val));
            write_cfg(CFG_W'(cfg_val));
            roll_base_histogram();
            repeat ($urandom_range(1, 3)) begin
                seg = $urandom_range(0, 9);
                if (seg == 0) begin
                    // Stray flush, possibly after a partial frame only
                    if ($urandom_range(0, 1) != 0)
                        push_bins(random_fill(), $urandom_range(1, BINS - 1));
                    push_flush();
                end else if (seg <= 5 && eff <= 6) begin
                    repeat (eff) push_bins(random_fill(), BINS);
                    random_made++;
                end else begin
                    k = $urandom_range(1, (eff <= 6) ? eff - 1 : 4);
                    repeat (k) push_bins(random_fill(), BINS);
                    if ($urandom_range(0, 1) != 0)
                        push_bins(random_fill(), $urandom_range(1, BINS - 1));
                    push_flush();
                    random_made++;
                end
            end
        end

        settle();
        $display("Checked %0d selections from %0d bin items over %0d register writes",
                 n_checked, n_accepted, n_cfg_writes);
        $display("Batch sizes 0 to 63, flushes with and without partial frames, a full");
        $display("32-frame batch and a long output hold-off were all driven");
        if (n_errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ filelist.f @@
design/hrfs_pkg.sv
design/hrfs_if.sv
design/hrfs_ram.sv
design/hrfs_ctrl.sv
design/hrfs_dp.sv
design/histogram_representative_frame_select_top.sv
design/hrfs_chk.sv
tb/histogram_representative_frame_select_top_tb.sv
